@@ rtl/drd_pkg.sv @@
// Package: shared types, codes and service byte table for the diagnostic response decoder.
`timescale 1ns / 1ps
package drd_pkg;

   // Default number of DTC records kept per response
   localparam int DEF_MAX_DTCS = 32;

   // Protocol constants
   localparam logic [7:0] NEG_REPLY  = 8'h7F;
   localparam logic [7:0] POS_OFFSET = 8'h40;
   localparam logic [8:0] POS_MAX    = 9'd511;

   // Service mode codes
   localparam logic [2:0] MODE_DTC     = 3'd0;
   localparam logic [2:0] MODE_ECU     = 3'd1;
   localparam logic [2:0] MODE_LOCAL   = 3'd2;
   localparam logic [2:0] MODE_COMMON  = 3'd3;
   localparam logic [2:0] MODE_PRESENT = 3'd4;

   // Verdict codes while a response is in progress
   localparam logic [2:0] V_FINE       = 3'd0;
   localparam logic [2:0] V_NEG        = 3'd1;
   localparam logic [2:0] V_MALFORMED  = 3'd3;
   localparam logic [2:0] V_UNEXPECTED = 3'd4;

   // Final status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NEGATIVE   = 3'd1;
   localparam logic [2:0] ST_INVALID    = 3'd2;
   localparam logic [2:0] ST_MALFORMED  = 3'd3;
   localparam logic [2:0] ST_UNEXPECTED = 3'd4;
   localparam logic [2:0] ST_TRUNCATED  = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_SERVICE_MODE = 2'd0;
   localparam logic [1:0] CSR_EXPECTED_ID  = 2'd1;
   localparam logic [1:0] CSR_PRESENCE     = 2'd2;

   // Tester present echo bytes
   localparam logic [7:0] ECHO_WANTED   = 8'h01;
   localparam logic [7:0] ECHO_UNWANTED = 8'h02;

   typedef struct packed {
      logic [2:0]  service_mode;
      logic [15:0] expected_id;
      logic        presence_reply_wanted;
   } cfg_type;

   typedef struct packed {
      logic [8:0] byte_position;
      logic [2:0] verdict;
      logic [7:0] ident_accum;
      logic [1:0] triple_phase;
      logic [7:0] code_high;
      logic [7:0] stated_count;
      logic [5:0] kept_count;
      logic [7:0] neg_code_held;
   } pdu_state_type;

   typedef struct packed {
      logic        record_valid;
      logic [15:0] dtc_code;
      logic [7:0]  dtc_status;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        done_res;
      logic [2:0]  status;
      logic [7:0]  negative_code;
      logic [7:0]  dtc_count;
      logic [5:0]  entries_kept;
   } result_type;

   // Request service byte for each mode
   function automatic logic [7:0] service_byte(input logic [2:0] mode);
      logic [7:0] svc;
      case (mode)
         MODE_DTC:     svc = 8'h18;
         MODE_ECU:     svc = 8'h1A;
         MODE_LOCAL:   svc = 8'h21;
         MODE_COMMON:  svc = 8'h22;
         MODE_PRESENT: svc = 8'h3E;
         default:      svc = 8'h00;
      endcase
      return svc;
   endfunction

endpackage

@@ rtl/drd_if.sv @@
// Interfaces: request byte channel and decoded result channel.
`timescale 1ns / 1ps
interface drd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface drd_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_valid;
   logic [15:0] dtc_code;
   logic [7:0]  dtc_status;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic        done_res;
   logic [2:0]  status;
   logic [7:0]  negative_code;
   logic [7:0]  dtc_count;
   logic [5:0]  entries_kept;

   modport source (output valid, output record_valid, output dtc_code, output dtc_status,
                   output payload_valid, output payload_byte, output done_res,
                   output status, output negative_code, output dtc_count,
                   output entries_kept, input ready);
   modport sink   (input valid, input record_valid, input dtc_code, input dtc_status,
                   input payload_valid, input payload_byte, input done_res,
                   input status, input negative_code, input dtc_count,
                   input entries_kept, output ready);
endinterface

@@ rtl/diag_response_decoder.sv @@
// Top level: diagnostic response decoder with config registers and two-deep result buffer.
//
//   channel    direction  handshake       word
//   req_chan   in         valid / ready   data_byte, last_byte
//   rsp_chan   out        valid / ready   DTC record, payload byte, final status
//   csr_*      in         write enable    service_mode, expected_id, presence_reply_wanted
//
// One byte per cycle while req_chan.ready is high; each result word is registered.
// The decode runs in a single pass from the response state register to the result
// register; a skid register lets one more byte in while the sink stalls.
// Synchronous reset clears the response state, the buffer and loads register defaults.
// req_chan.ready drops only when both result and skid registers are full.
`timescale 1ns / 1ps
module diag_response_decoder
   import drd_pkg::*;
#(
   parameter int MAX_DTCS = DEF_MAX_DTCS
) (
   input  logic        clock,
   input  logic        reset,
   drd_req_if.sink     req_chan,
   drd_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   cfg_type       cfg_ff;
   pdu_state_type state_ff;
   pdu_state_type state_in;
   result_type    result_in;
   result_type    out_ff;
   result_type    skid_ff;
   logic          out_valid_ff;
   logic          skid_valid_ff;
   logic          take_in;
   logic          take_out;

   drd_step #(
      .MAX_DTCS (MAX_DTCS)
   ) u_step (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .nxt       (state_in),
      .res       (result_in)
   );

   assign req_chan.ready = !skid_valid_ff;
   assign take_in  = req_chan.valid && !skid_valid_ff;
   assign take_out = out_valid_ff && rsp_chan.ready;

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.service_mode          <= MODE_DTC;
         cfg_ff.expected_id           <= 16'h0000;
         cfg_ff.presence_reply_wanted <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SERVICE_MODE: cfg_ff.service_mode          <= csr_write_data[2:0];
            CSR_EXPECTED_ID:  cfg_ff.expected_id           <= csr_write_data;
            CSR_PRESENCE:     cfg_ff.presence_reply_wanted <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Advance response state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (take_in) begin
         state_ff <= state_in;
      end
   end

   // Result and skid valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take_out) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= take_in;
         end
      end else if (take_in) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Result and skid words
   always_ff @(posedge clock) begin
      if (!out_valid_ff || take_out) begin
         out_ff <= skid_valid_ff ? skid_ff : result_in;
      end else if (take_in) begin
         skid_ff <= result_in;
      end
   end

   // Drive the result channel
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.record_valid   = out_ff.record_valid;
   assign rsp_chan.dtc_code       = out_ff.dtc_code;
   assign rsp_chan.dtc_status     = out_ff.dtc_status;
   assign rsp_chan.payload_valid  = out_ff.payload_valid;
   assign rsp_chan.payload_byte   = out_ff.payload_byte;
   assign rsp_chan.done_res       = out_ff.done_res;
   assign rsp_chan.status         = out_ff.status;
   assign rsp_chan.negative_code  = out_ff.negative_code;
   assign rsp_chan.dtc_count      = out_ff.dtc_count;
   assign rsp_chan.entries_kept   = out_ff.entries_kept;

endmodule

@@ rtl/drd_step.sv @@
// Per-byte decode logic: next response state and result word from one input byte.
`timescale 1ns / 1ps
module drd_step
   import drd_pkg::*;
#(
   parameter int MAX_DTCS = DEF_MAX_DTCS
) (
   input  cfg_type       cfg,
   input  pdu_state_type cur,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   output pdu_state_type nxt,
   output result_type    res
);

   localparam logic [5:0] MaxKept   = 6'(MAX_DTCS);
   localparam logic [7:0] MaxStated = 8'(MAX_DTCS);

   logic [2:0] mode;
   logic [8:0] pos;
   logic [7:0] svc;
   logic [7:0] echo;
   logic       bad_arg;
   logic [2:0] st;

   assign mode = cfg.service_mode;
   assign pos  = cur.byte_position;
   assign svc  = service_byte(mode);
   assign echo = cfg.presence_reply_wanted ? ECHO_WANTED : ECHO_UNWANTED;
   assign bad_arg = (mode > MODE_PRESENT) ||
                    ((mode inside {MODE_ECU, MODE_LOCAL}) && (cfg.expected_id[7:0] == 8'h00));

   always_comb begin
      nxt = cur;
      res = '0;
      st  = ST_OK;

      // Judge the byte against the configured service
      if (!bad_arg) begin
         if (pos == 9'd0) begin
            if (data_byte == NEG_REPLY) begin
               nxt.verdict = V_NEG;
            end else if (data_byte != 8'(svc + POS_OFFSET)) begin
               nxt.verdict = V_UNEXPECTED;
            end
         end else if (cur.verdict == V_NEG) begin
            if (pos == 9'd1) begin
               if (data_byte != svc) nxt.verdict = V_MALFORMED;
            end else if (pos == 9'd2) begin
               nxt.neg_code_held = data_byte;
               if (data_byte == 8'h00) nxt.verdict = V_MALFORMED;
            end else begin
               nxt.verdict = V_MALFORMED;
            end
         end else if (cur.verdict == V_FINE) begin
            case (mode)
               MODE_DTC: begin
                  if (pos == 9'd1) begin
                     nxt.stated_count = data_byte;
                     nxt.ident_accum  = 8'h00;
                     nxt.triple_phase = 2'd0;
                  end else if (cur.ident_accum < cur.stated_count) begin
                     // Collect code high, code low, status; emit on status while below MaxKept records
                     if (cur.triple_phase == 2'd0) begin
                        nxt.code_high    = data_byte;
                        nxt.triple_phase = 2'd1;
                     end else if (cur.triple_phase == 2'd1) begin
                        nxt.neg_code_held = data_byte;
                        nxt.triple_phase  = 2'd2;
                     end else begin
                        if (cur.kept_count < MaxKept) begin
                           res.record_valid = 1'b1;
                           res.dtc_code     = {cur.code_high, cur.neg_code_held};
                           res.dtc_status   = data_byte;
                           nxt.kept_count   = cur.kept_count + 6'd1;
                        end
                        nxt.ident_accum  = cur.ident_accum + 8'd1;
                        nxt.triple_phase = 2'd0;
                     end
                  end
               end
               MODE_ECU, MODE_LOCAL: begin
                  if (pos == 9'd1) begin
                     if (data_byte != cfg.expected_id[7:0]) nxt.verdict = V_UNEXPECTED;
                  end else begin
                     res.payload_valid = 1'b1;
                     res.payload_byte  = data_byte;
                  end
               end
               MODE_COMMON: begin
                  if (pos == 9'd1) begin
                     nxt.ident_accum = data_byte;
                  end else if (pos == 9'd2) begin
                     if ({cur.ident_accum, data_byte} != cfg.expected_id)
                        nxt.verdict = V_UNEXPECTED;
                  end else begin
                     res.payload_valid = 1'b1;
                     res.payload_byte  = data_byte;
                  end
               end
               default: begin
                  // Tester present: at most one byte after the reply, the matching echo
                  if ((pos != 9'd1) || (data_byte != echo)) nxt.verdict = V_UNEXPECTED;
               end
            endcase
         end
      end

      // Report final status on the last byte, then clear for the next response
      if (last_byte) begin
         if (bad_arg) begin
            st = ST_INVALID;
         end else if (nxt.verdict == V_UNEXPECTED) begin
            st = ST_UNEXPECTED;
         end else if (nxt.verdict == V_MALFORMED) begin
            st = ST_MALFORMED;
         end else if (nxt.verdict == V_NEG) begin
            st = (pos == 9'd2) ? ST_NEGATIVE : ST_MALFORMED;
         end else if (pos == 9'd0) begin
            st = (mode == MODE_PRESENT) ? ST_OK : ST_MALFORMED;
         end else if (mode == MODE_DTC) begin
            if (nxt.ident_accum < nxt.stated_count) st = ST_MALFORMED;
            else st = (nxt.stated_count > MaxStated) ? ST_TRUNCATED : ST_OK;
         end else if (mode == MODE_COMMON) begin
            st = (pos < 9'd2) ? ST_MALFORMED : ST_OK;
         end else begin
            st = ST_OK;
         end
         res.done_res = 1'b1;
         res.status   = st;
         if (st == ST_NEGATIVE) res.negative_code = nxt.neg_code_held;
         if (!bad_arg && (mode == MODE_DTC) && ((st == ST_OK) || (st == ST_TRUNCATED))) begin
            res.dtc_count    = nxt.stated_count;
            res.entries_kept = nxt.kept_count;
         end
         nxt = '0;
      end else if (pos < POS_MAX) begin
         nxt.byte_position = pos + 9'd1;
      end
   end

endmodule
